### hw/rtl/ptt_pkg.sv
// shared types and codes for the pending transaction table
// no dependencies
package ptt_pkg;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_DELETE = 3'd1;
  localparam logic [2:0] KIND_LOOKUP = 3'd2;
  localparam logic [2:0] KIND_SETTTL = 3'd3;
  localparam logic [2:0] KIND_TICK   = 3'd4;
  localparam logic [2:0] KIND_PURGE  = 3'd5;

  localparam logic [15:0] TTL_RESET = 16'd10;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] txn_id;
    logic [7:0]  iface_id;
    logic [7:0]  func_id;
    logic [15:0] parent_txn;
    logic [7:0]  parent_state;
    logic [15:0] ttl_value;
  } req_t;

  typedef struct packed {
    logic        found;
    logic        table_full;
    logic [7:0]  hit_iface;
    logic [7:0]  hit_func;
    logic [15:0] hit_parent;
    logic [7:0]  hit_parent_state;
    logic [15:0] hit_ttl;
    logic [4:0]  removed_count;
  } rsp_t;

  // one table entry
  typedef struct packed {
    logic [15:0] txn;
    logic [7:0]  iface;
    logic [7:0]  func;
    logic [15:0] parent;
    logic [7:0]  pstate;
    logic [15:0] ttl;
  } entry_t;

  // classified command from front to back
  typedef struct packed {
    logic        is_add;
    logic        is_delete;
    logic        is_lookup;
    logic        is_setttl;
    logic        is_tick;
    logic        is_purge;
    req_t        req;
  } cmd_t;

endpackage

### hw/rtl/ptt_front.sv
// front end: accepts items, classifies the kind, holds a two-entry command queue
// depends on ptt_pkg
module ptt_front import ptt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_req,
  output logic cmd_valid,
  input  logic cmd_take,
  output cmd_t cmd
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       c;
  logic       push;
  logic       pop;

  always_comb begin
    c = '0;
    c.req = in_req;
    unique case (in_req.kind)
      KIND_ADD:    c.is_add = 1'b1;
      KIND_DELETE: c.is_delete = 1'b1;
      KIND_LOOKUP: c.is_lookup = 1'b1;
      KIND_SETTTL: c.is_setttl = 1'b1;
      KIND_TICK:   c.is_tick = 1'b1;
      KIND_PURGE:  c.is_purge = 1'b1;
      default:     c.is_add = 1'b0;
    endcase
  end

  assign in_stall  = fill[1];
  assign push      = in_valid && !in_stall;
  assign cmd_valid = fill != 2'd0;
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= c;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### hw/rtl/ptt_back.sv
// back end: table storage and the per-slot scan that carries out each command
// depends on ptt_pkg
module ptt_back import ptt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] ttl_default,
  input  logic        cmd_valid,
  output logic        cmd_take,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_stall,
  output rsp_t        out_rsp,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] live_count
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH+1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam rsp_t RSP_FULL = '{table_full: 1'b1, default: '0};

  entry_t     slot [TABLE_DEPTH];
  logic [1:0] state;
  cmd_t       cur;
  logic [CW-1:0] idx;   // read position
  logic [CW-1:0] keep;  // write position while compacting
  logic       hit;
  logic [4:0] removed;
  rsp_t       rsp;
  entry_t     e;

  assign e        = slot[idx[IW-1:0]];
  assign cmd_take = (state == ST_IDLE) && cmd_valid && !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      live_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd_take) begin
            cur     <= cmd;
            idx     <= cmd.is_add ? live_count : '0;
            keep    <= '0;
            hit     <= 1'b0;
            removed <= '0;
            rsp     <= (cmd.is_add && live_count == CW'(TABLE_DEPTH)) ? RSP_FULL : '0;
            if (cmd.is_add && live_count == CW'(TABLE_DEPTH)) begin
              state <= ST_DONE;
            end else if (cmd.is_add || cmd.is_delete || cmd.is_lookup ||
                         cmd.is_setttl || cmd.is_tick || cmd.is_purge) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          if (cur.is_add) begin
            // shift down one place from the tail, then write the head
            if (idx == '0) begin
              slot[0] <= '{cur.req.txn_id, cur.req.iface_id, cur.req.func_id,
                           cur.req.parent_txn, cur.req.parent_state, ttl_default};
              live_count <= live_count + 1'b1;
              rsp.found  <= 1'b1;
              state      <= ST_DONE;
            end else begin
              slot[idx[IW-1:0]] <= slot[idx[IW-1:0] - 1'b1];
              idx <= idx - 1'b1;
            end
          end else if (idx >= live_count) begin
            if (cur.is_purge) begin
              live_count        <= keep;
              rsp.removed_count <= removed;
            end else if (cur.is_delete && hit) begin
              live_count        <= live_count - 1'b1;
              rsp.removed_count <= 5'd1;
            end
            state <= ST_DONE;
          end else begin
            if (cur.is_tick) begin
              idx <= idx + 1'b1;
              if (e.ttl != 16'd0) slot[idx[IW-1:0]].ttl <= e.ttl - 1'b1;
            end else if (cur.is_purge) begin
              idx <= idx + 1'b1;
              if (e.ttl == 16'd0) removed <= removed + 1'b1;
              else begin
                slot[keep[IW-1:0]] <= e;
                keep <= keep + 1'b1;
              end
            end else if (cur.is_delete && hit) begin
              // close the gap left by the removed entry
              idx <= idx + 1'b1;
              slot[idx[IW-1:0] - 1'b1] <= e;
            end else if (e.txn == cur.req.txn_id) begin
              hit                  <= 1'b1;
              rsp.found            <= 1'b1;
              rsp.hit_iface        <= e.iface;
              rsp.hit_func         <= e.func;
              rsp.hit_parent       <= e.parent;
              rsp.hit_parent_state <= e.pstate;
              if (cur.is_setttl) begin
                slot[idx[IW-1:0]].ttl <= cur.req.ttl_value;
                rsp.hit_ttl <= cur.req.ttl_value;
              end else begin
                rsp.hit_ttl <= e.ttl;
              end
              idx <= cur.is_delete ? idx + 1'b1 : live_count;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (!(out_valid && out_stall)) begin
            out_rsp   <= rsp;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/pending_transaction_table_ttl.sv
// top level of the pending transaction table with ttl aging
// depends on ptt_pkg, ptt_front, ptt_back
//
// usage:
//   input channel in_valid/in_stall/in_req carries one command item
//   (add, delete, lookup, set ttl, tick, purge); output channel
//   out_valid/out_stall/out_rsp returns exactly one result item per command.
//   ttl_default_we/ttl_default write the default ttl (10 after reset).
// operation:
//   a front queue of two items takes commands while the back end works.
//   the back end walks the live slots one per cycle through the single
//   table read port and takes no new command until its result is out;
//   lookups stop at the first match, unknown kinds and refused adds
//   skip the scan.
// reset:
//   synchronous rst empties the table and the queue and restores the default ttl.
// stall:
//   a result waits in the output register while out_stall is high; the back
//   end holds its next result, and the queue fills and then stalls the input.
module pending_transaction_table_ttl import ptt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        ttl_default_we,
  input  logic [15:0] ttl_default,
  input  logic        in_valid,
  output logic        in_stall,
  input  req_t        in_req,
  output logic        out_valid,
  input  logic        out_stall,
  output rsp_t        out_rsp
);

  logic [15:0] ttl_reg;
  logic        cmd_valid;
  logic        cmd_take;
  cmd_t        cmd;
  logic [$clog2(TABLE_DEPTH+1)-1:0] live_count;

  always_ff @(posedge clk) begin
    if (rst) ttl_reg <= TTL_RESET;
    else if (ttl_default_we) ttl_reg <= ttl_default;
  end

  ptt_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_req,
    .cmd_valid, .cmd_take, .cmd
  );

  ptt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst, .ttl_default(ttl_reg), .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_stall, .out_rsp, .live_count
  );

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= ($clog2(TABLE_DEPTH+1))'(TABLE_DEPTH))
    else $error("live count beyond table depth");

  a_full_no_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_rsp.found && out_rsp.table_full))
    else $error("result both found and full");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed");

endmodule
